FILE: rtl/hnm_pkg.sv
// Shared types and constants for the height-to-normal-map block.
// No dependencies; every other file of the block but hnm_if imports this package.
package hnm_pkg;

   // Default largest row length held in the row store
   localparam int DEF_MAX_WIDTH = 1024;

   // Depth of the job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Unit length of the vertical component (1.0 as a 16-bit fraction)
   localparam logic [15:0] NORM_ONE = 16'd65535;

   // Q1.15 full scale used for the output scaling
   localparam logic [14:0] Q15_MAX = 15'd32767;

   // Configuration register indexes
   typedef enum logic [1:0] {
      REG_SRC_WIDTH     = 2'd0,
      REG_SRC_HEIGHT    = 2'd1,
      REG_SAMPLE_FORMAT = 2'd2
   } csr_reg_type;

   // Sample format codes
   localparam logic FMT_8BIT  = 1'b0;
   localparam logic FMT_16BIT = 1'b1;

   // One classified job handed from front to back
   typedef struct packed {
      logic        neg_x;
      logic        neg_z;
      logic [15:0] diff_x;
      logic [15:0] diff_z;
      logic        end_of_row;
      logic        end_of_frame;
   } job_type;

endpackage

FILE: rtl/hnm_if.sv
// Channel interfaces of the height-to-normal-map block.
// Depends on nothing; used by the top level and the front and back modules.
interface hnm_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] height_sample;

   modport source (output valid, output height_sample, input ready);
   modport sink   (input valid, input height_sample, output ready);
endinterface

interface hnm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;
   logic               end_of_row;
   logic               end_of_frame;

   modport source (output valid, output normal_x, output normal_y, output normal_z,
                   output end_of_row, output end_of_frame, input ready);
   modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                   input end_of_row, input end_of_frame, output ready);
endinterface

interface hnm_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/hnm_fifo.sv
// Short job queue between the front and back parts.
// Depends on hnm_pkg for the job type and queue depth.
module hnm_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hnm_pkg::job_type push_data,
   input  logic             pop,
   output hnm_pkg::job_type pop_data,
   output logic             full,
   output logic             empty
);
   import hnm_pkg::*;

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W:0]     count_ff;

   assign full     = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // Store payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < (QPTR_W+1)'(QUEUE_DEPTH)))
      else $error("job queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("job queue read while empty");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("job queue count did not advance on push");

   a_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
      else $error("job queue count out of range");

endmodule

FILE: rtl/hnm_front.sv
// Front part: configuration registers, raster counters, row store and job classification.
// Depends on hnm_pkg and the request and configuration interfaces in hnm_if.
module hnm_front #(
   parameter int MAX_WIDTH = hnm_pkg::DEF_MAX_WIDTH,
   parameter int EW        = $clog2(MAX_WIDTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   hnm_req_if.sink          req_ch,
   hnm_csr_if.sink          csr_ch,
   input  logic             q_full,
   output logic             q_push,
   output hnm_pkg::job_type q_data,
   output logic [EW-1:0]    eff_width,
   output logic [15:0]      eff_height
);
   import hnm_pkg::*;

   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int CMPW = (EW > 11) ? EW : 11;

   logic [10:0]   width_ff;
   logic [15:0]   height_ff;
   logic          format_ff;
   logic [CW-1:0] col_ff;
   logic [15:0]   row_ff;
   logic [15:0]   prev_ff;
   logic [15:0]   row_mem [MAX_WIDTH];

   // First stage holding register
   logic          s1_valid_ff;
   logic          s1_emit_ff;
   logic [15:0]   s1_cur_ff;
   logic [15:0]   s1_left_ff;
   logic [15:0]   s1_above_ff;
   logic          s1_eor_ff;
   logic          s1_eof_ff;

   logic [CMPW-1:0] width_ext;
   logic [15:0]     sample;
   logic            accept;
   logic            csr_write;
   logic            last_col;
   logic            last_row;

   // Clamp configured sizes
   always_comb begin
      width_ext = CMPW'(width_ff);
      if (width_ext < CMPW'(2)) begin
         eff_width = EW'(2);
      end else if (width_ext > CMPW'(MAX_WIDTH)) begin
         eff_width = EW'(MAX_WIDTH);
      end else begin
         eff_width = EW'(width_ext);
      end
      eff_height = (height_ff < 16'd2) ? 16'd2 : height_ff;
   end

   // Widen 8-bit samples by 257
   assign sample = (format_ff == FMT_16BIT) ? req_ch.height_sample
                                            : {req_ch.height_sample[7:0],
                                               req_ch.height_sample[7:0]};

   assign last_col  = (EW'(col_ff) == eff_width - EW'(1));
   assign last_row  = (row_ff == eff_height - 16'd1);
   assign csr_write = csr_ch.valid && csr_ch.ready;
   assign csr_ch.ready = 1'b1;

   // Take a sample when the holding stage is free or drains this cycle
   assign req_ch.ready = !s1_valid_ff || !s1_emit_ff || !q_full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign q_push       = s1_valid_ff && s1_emit_ff && !q_full;

   // Classify the job at the queue input
   always_comb begin
      q_data.neg_x        = s1_left_ff < s1_cur_ff;
      q_data.neg_z        = s1_above_ff < s1_cur_ff;
      q_data.diff_x       = q_data.neg_x ? s1_cur_ff - s1_left_ff : s1_left_ff - s1_cur_ff;
      q_data.diff_z       = q_data.neg_z ? s1_cur_ff - s1_above_ff : s1_above_ff - s1_cur_ff;
      q_data.end_of_row   = s1_eor_ff;
      q_data.end_of_frame = s1_eof_ff;
   end

   // Row store: read old row entry, write current sample
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_above_ff     <= row_mem[col_ff];
         row_mem[col_ff] <= sample;
      end
   end

   // Capture sample payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cur_ff  <= sample;
         s1_left_ff <= prev_ff;
         s1_emit_ff <= (col_ff != '0) && (row_ff != '0);
         s1_eor_ff  <= last_col;
         s1_eof_ff  <= last_col && last_row;
         prev_ff    <= sample;
      end
   end

   // Holding stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_valid_ff && (!s1_emit_ff || !q_full)) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // Configuration writes and raster counters
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 11'd1024;
         height_ff <= 16'd1024;
         format_ff <= FMT_8BIT;
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_write) begin
         unique case (csr_ch.index)
            REG_SRC_WIDTH:     width_ff  <= csr_ch.data[10:0];
            REG_SRC_HEIGHT:    height_ff <= csr_ch.data;
            REG_SAMPLE_FORMAT: format_ff <= csr_ch.data[0];
            default: ;
         endcase
         if (csr_ch.index == REG_SRC_WIDTH || csr_ch.index == REG_SRC_HEIGHT ||
             csr_ch.index == REG_SAMPLE_FORMAT) begin
            col_ff <= '0;
            row_ff <= '0;
         end
      end else if (accept) begin
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? 16'd0 : row_ff + 16'd1;
         end else begin
            col_ff <= col_ff + 1'b1;
         end
      end
   end

endmodule

FILE: rtl/hnm_back.sv
// Back part: scales the differences, finds the vector length and divides out each component.
// Depends on hnm_pkg and the result interface in hnm_if.
module hnm_back #(
   parameter int EW = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [EW-1:0]    eff_width,
   input  logic [15:0]      eff_height,
   input  logic             q_empty,
   input  hnm_pkg::job_type q_data,
   output logic             q_pop,
   hnm_rsp_if.source        rsp_ch
);
   import hnm_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_MUL   = 8'b0000_0010,
      ST_SHIFT = 8'b0000_0100,
      ST_SQ    = 8'b0000_1000,
      ST_ROOT  = 8'b0001_0000,
      ST_DSET  = 8'b0010_0000,
      ST_DIV   = 8'b0100_0000,
      ST_DONE  = 8'b1000_0000
   } state_type;

   state_type     state_ff;
   job_type       job_ff;
   logic [31:0]   mx_ff;
   logic [31:0]   mz_ff;
   logic [29:0]   cx_ff;
   logic [29:0]   cy_ff;
   logic [29:0]   cz_ff;
   logic [59:0]   prod_ff;
   logic [61:0]   acc_ff;
   logic [61:0]   res_ff;
   logic [61:0]   bit_ff;
   logic [30:0]   len_ff;
   logic [45:0]   rem_ff;
   logic [45:0]   dvs_ff;
   logic [15:0]   quo_ff;
   logic [15:0]   qx_ff;
   logic [15:0]   qy_ff;
   logic [15:0]   qz_ff;
   logic [4:0]    cnt_ff;
   logic [1:0]    comp_ff;
   logic          out_valid_ff;

   logic [31:0]   mmax;
   logic [1:0]    shamt;
   logic [29:0]   sq_op;
   logic [29:0]   div_op;
   logic [61:0]   trial;
   logic          out_free;

   // Pick the larger scaled magnitude and its shift
   always_comb begin
      mmax  = (mx_ff > mz_ff) ? mx_ff : mz_ff;
      shamt = mmax[31] ? 2'd2 : (mmax[30] ? 2'd1 : 2'd0);
   end

   // Operand selection for the shared squarer and divider
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    sq_op = cx_ff;
         2'd1:    sq_op = cy_ff;
         default: sq_op = cz_ff;
      endcase
      case (comp_ff)
         2'd0:    div_op = cx_ff;
         2'd1:    div_op = cy_ff;
         default: div_op = cz_ff;
      endcase
   end

   assign trial    = res_ff + bit_ff;
   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;

   // Sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE:  if (!q_empty) state_ff <= ST_MUL;
            ST_MUL:   state_ff <= ST_SHIFT;
            ST_SHIFT: state_ff <= ST_SQ;
            ST_SQ:    if (cnt_ff == 5'd3) state_ff <= ST_ROOT;
            ST_ROOT:  if (cnt_ff == 5'd30) state_ff <= ST_DSET;
            ST_DSET:  state_ff <= ST_DIV;
            ST_DIV: begin
               if (cnt_ff == 5'd15) begin
                  state_ff <= (comp_ff == 2'd2) ? ST_DONE : ST_DSET;
               end
            end
            ST_DONE:  if (out_free) state_ff <= ST_IDLE;
            default:  state_ff <= ST_IDLE;
         endcase
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            job_ff <= q_data;
         end
         ST_MUL: begin
            mx_ff <= 32'(job_ff.diff_x * eff_width);
            mz_ff <= 32'(job_ff.diff_z * eff_height);
         end
         ST_SHIFT: begin
            cx_ff  <= 30'(mx_ff >> shamt);
            cy_ff  <= 30'({16'd0, NORM_ONE} >> shamt);
            cz_ff  <= 30'(mz_ff >> shamt);
            cnt_ff <= '0;
            acc_ff <= '0;
         end
         ST_SQ: begin
            // Square one component a cycle, accumulate it in the next cycle
            prod_ff <= sq_op * sq_op;
            if (cnt_ff != '0) begin
               acc_ff <= acc_ff + 62'(prod_ff);
            end
            if (cnt_ff == 5'd3) begin
               cnt_ff <= '0;
               res_ff <= '0;
               bit_ff <= 62'd1 << 60;
            end else begin
               cnt_ff <= cnt_ff + 5'd1;
            end
         end
         ST_ROOT: begin
            // One result bit per cycle
            if (acc_ff >= trial) begin
               acc_ff <= acc_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            if (cnt_ff == 5'd30) begin
               len_ff  <= (acc_ff >= trial) ? 31'((res_ff >> 1) + bit_ff) : 31'(res_ff >> 1);
               comp_ff <= 2'd0;
            end
            cnt_ff <= cnt_ff + 5'd1;
         end
         ST_DSET: begin
            rem_ff <= 46'(div_op * Q15_MAX) + 46'(len_ff >> 1);
            dvs_ff <= 46'(len_ff) << 15;
            quo_ff <= '0;
            cnt_ff <= '0;
         end
         ST_DIV: begin
            // One quotient bit per cycle
            if (rem_ff >= dvs_ff) begin
               rem_ff <= rem_ff - dvs_ff;
               quo_ff <= {quo_ff[14:0], 1'b1};
            end else begin
               quo_ff <= {quo_ff[14:0], 1'b0};
            end
            dvs_ff <= dvs_ff >> 1;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd15) begin
               case (comp_ff)
                  2'd0:    qx_ff <= {quo_ff[14:0], rem_ff >= dvs_ff};
                  2'd1:    qy_ff <= {quo_ff[14:0], rem_ff >= dvs_ff};
                  default: qz_ff <= {quo_ff[14:0], rem_ff >= dvs_ff};
               endcase
               comp_ff <= comp_ff + 2'd1;
            end
         end
         ST_DONE: ;
         default: ;
      endcase
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_ch.normal_x     <= job_ff.neg_x ? 16'(~qx_ff + 16'd1) : qx_ff;
         rsp_ch.normal_y     <= qy_ff;
         rsp_ch.normal_z     <= job_ff.neg_z ? 16'(~qz_ff + 16'd1) : qz_ff;
         rsp_ch.end_of_row   <= job_ff.end_of_row;
         rsp_ch.end_of_frame <= job_ff.end_of_frame;
      end
   end

   assign rsp_ch.valid = out_valid_ff;

endmodule

FILE: rtl/height_to_normal_map.sv
// Height samples enter in raster order at one per cycle, held back while the job queue
// is full, and are classified by the front part, which keeps the row store (one
// single-port memory of MAX_WIDTH words) and the raster counters; samples in the first
// row or column leave no result. Every other sample becomes a job in a four-entry queue.
// The back part handles one job at a time, in order: a multiply step, a shift step,
// a shared squarer, a bit-serial square root and three bit-serial divisions on the
// shared divider, and takes no new job until the last one is done. Results wait in an
// output register while the back part starts the next job.
module height_to_normal_map #(
   parameter int MAX_WIDTH = hnm_pkg::DEF_MAX_WIDTH
) (
   input  logic      clock,
   input  logic      reset,
   hnm_req_if.sink   req_ch,
   hnm_rsp_if.source rsp_ch,
   hnm_csr_if.sink   csr_ch
);
   import hnm_pkg::*;

   localparam int EW = $clog2(MAX_WIDTH + 1);

   job_type        push_data;
   job_type        pop_data;
   logic           push;
   logic           pop;
   logic           full;
   logic           empty;
   logic [EW-1:0]  eff_width;
   logic [15:0]    eff_height;

   // Accept and classify samples
   hnm_front #(
      .MAX_WIDTH (MAX_WIDTH),
      .EW        (EW)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .csr_ch     (csr_ch),
      .q_full     (full),
      .q_push     (push),
      .q_data     (push_data),
      .eff_width  (eff_width),
      .eff_height (eff_height)
   );

   // Decouple front and back
   hnm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (full),
      .empty     (empty)
   );

   // Compute the unit normal
   hnm_back #(
      .EW (EW)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .eff_width  (eff_width),
      .eff_height (eff_height),
      .q_empty    (empty),
      .q_data     (pop_data),
      .q_pop      (pop),
      .rsp_ch     (rsp_ch)
   );

endmodule

FILE: bench/height_to_normal_map_test.sv
// Self-checking testbench for height_to_normal_map: directed frames, one full-width
// pass and randomized frames, checked against a built-in normal-map predictor.
// Depends on rtl/hnm_pkg.sv, rtl/hnm_if.sv and rtl/height_to_normal_map.sv.
`timescale 1ns / 100ps

module height_to_normal_map_test;
   import hnm_pkg::*;

   localparam int HALF_PERIOD = 4;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 150;
   localparam int ITEM_GOAL   = 1750;
   localparam int IDLE_PCT    = 27;

   typedef struct packed {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic               eor;
      logic               eof;
   } normal_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   hnm_req_if req ();
   hnm_rsp_if rsp ();
   hnm_csr_if csr ();

   height_to_normal_map dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp),
      .csr_ch (csr)
   );

   always #HALF_PERIOD clock = ~clock;

   // predictor state
   logic [15:0] row_mem [DEF_MAX_WIDTH];
   logic [15:0] left_height;
   int unsigned col_pos, row_pos;
   logic [10:0] width_reg  = 11'd1024;
   logic [15:0] height_reg = 16'd1024;
   logic        format_reg = FMT_8BIT;

   normal_type  pending_normals [$];
   int          error_count = 0;
   int          items_sent = 0;
   bit          steady = 1'b0;
   int unsigned cycle_count = 0;

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned root, bit_val;
      root    = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > v) bit_val = bit_val >> 2;
      while (bit_val != 0) begin
         if (v >= root + bit_val) begin
            v    = v - (root + bit_val);
            root = (root >> 1) + bit_val;
         end else begin
            root = root >> 1;
         end
         bit_val = bit_val >> 2;
      end
      return root;
   endfunction

   function automatic logic [15:0] scale_q15(input bit neg, input longint unsigned mag,
                                             input longint unsigned len);
      longint unsigned q;
      q = (64'd32767 * mag + len / 2) / len;
      return neg ? 16'(-q) : 16'(q);
   endfunction

   // advance the raster state by one sample and queue the normal it yields
   task automatic predict_normal(input logic [15:0] raw);
      int unsigned w, h, c, r;
      logic [15:0] v, above;
      bit          neg_x, neg_z;
      longint unsigned dx, dz, mx, my, mz, m, len;
      int          s;
      normal_type  e;
      w = (width_reg < 2) ? 2 : ((width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg);
      h = (height_reg < 2) ? 2 : height_reg;
      v = (format_reg == FMT_16BIT) ? raw : {raw[7:0], raw[7:0]};
      c = (col_pos >= DEF_MAX_WIDTH) ? 0 : col_pos;
      r = row_pos;
      if (c >= 1 && r >= 1) begin
         above = row_mem[c];
         neg_x = left_height < v;
         neg_z = above < v;
         dx = neg_x ? v - left_height : left_height - v;
         dz = neg_z ? v - above : above - v;
         mx = dx * w;
         my = NORM_ONE;
         mz = dz * h;
         m  = (mx > mz) ? mx : mz;
         s  = (m >= (64'd1 << 31)) ? 2 : ((m >= (64'd1 << 30)) ? 1 : 0);
         mx = mx >> s;
         my = my >> s;
         mz = mz >> s;
         len   = int_sqrt(mx * mx + my * my + mz * mz);
         e.nx  = scale_q15(neg_x, mx, len);
         e.ny  = scale_q15(1'b0, my, len);
         e.nz  = scale_q15(neg_z, mz, len);
         e.eor = (c == w - 1);
         e.eof = (c == w - 1) && (r == h - 1);
         pending_normals.push_back(e);
      end
      row_mem[c]  = v;
      left_height = v;
      c++;
      if (c >= w) begin
         c = 0;
         r++;
         if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
   endtask

   // send one height sample, sometimes after a random gap when not in steady mode
   task automatic send_height(input logic [15:0] value);
      if (!steady && $urandom_range(99) < IDLE_PCT) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req.valid         <= 1'b1;
      req.height_sample <= value;
      do @(posedge clock); while (!req.ready);
      predict_normal(value);
      items_sent++;
   endtask

   // wait out every pending normal plus the back-end latency
   task automatic drain;
      req.valid <= 1'b0;
      while (pending_normals.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [15:0] value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      case (idx)
         REG_SRC_WIDTH:  width_reg  = value[10:0];
         REG_SRC_HEIGHT: height_reg = value;
         default:        format_reg = value[0];
      endcase
      col_pos = 0;
      row_pos = 0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] w, input logic [15:0] h, input logic fmt);
      write_reg(REG_SRC_WIDTH, w);
      write_reg(REG_SRC_HEIGHT, h);
      write_reg(REG_SAMPLE_FORMAT, {15'd0, fmt});
   endtask

   // smallest frames: extremes, flat patches, out-of-range sizes, ignored upper bits
   task automatic test_directed;
      logic [15:0] pattern [24];
      pattern = '{16'h0000, 16'h0000, 16'h0000, 16'hFFFF,
                  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
                  16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000,
                  16'h1234, 16'h1234, 16'h1234, 16'h1234,
                  16'hFF00, 16'h00FF, 16'h12FF, 16'hAB00,
                  16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF};
      configure(16'd1, 16'd0, FMT_16BIT);
      for (int i = 0; i < 16; i++) send_height(pattern[i]);
      drain();
      write_reg(REG_SAMPLE_FORMAT, {15'd0, FMT_8BIT});
      for (int i = 16; i < 24; i++) send_height(pattern[i]);
      drain();
   endtask

   // widest row: a random first row sent without gaps, then steep steps at the start of the next row
   task automatic test_full_width;
      configure(16'd2047, 16'd1, FMT_16BIT);
      steady = 1'b1;
      for (int i = 0; i < DEF_MAX_WIDTH; i++) send_height(16'($urandom));
      steady = 1'b0;
      for (int i = 0; i < 40; i++) send_height((i % 2) ? 16'hFFFF : 16'h0000);
      drain();
   endtask

   // random frame sizes and formats with smooth, steep and noisy height fields
   task automatic test_random_frames;
      logic [15:0] w, h, sample;
      int          n, style;
      while (items_sent < ITEM_GOAL) begin
         w = ($urandom_range(9) == 0) ? 16'($urandom_range(13, 64)) : 16'($urandom_range(0, 12));
         case ($urandom_range(5))
            0:       h = 16'hFFFF;
            1:       h = 16'($urandom_range(16384, 40000));
            default: h = 16'($urandom_range(0, 6));
         endcase
         configure(w, h, 1'($urandom));
         n = $urandom_range(30, 120);
         sample = 16'($urandom);
         for (int i = 0; i < n; i++) begin
            style = $urandom_range(9);
            if (style < 5)      sample = sample + 16'($signed($urandom_range(0, 64)) - 32);
            else if (style < 7) sample = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            else                sample = 16'($urandom);
            send_height(sample);
         end
         drain();
      end
   endtask

   // result channel back-pressure
   always @(posedge clock) begin
      rsp.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // compare each transfer with the oldest expected normal
   always @(posedge clock) begin
      normal_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.normal_x, rsp.normal_y, rsp.normal_z, rsp.end_of_row, rsp.end_of_frame};
         if (pending_normals.size() == 0) begin
            $display("%0t: unexpected normal x=%0d y=%0d z=%0d eor=%0b eof=%0b", $time,
                     got.nx, got.ny, got.nz, got.eor, got.eof);
            error_count++;
         end else begin
            want = pending_normals.pop_front();
            if (got !== want) begin
               $display("%0t: normal mismatch expected x=%0d y=%0d z=%0d eor=%0b eof=%0b",
                        $time, want.nx, want.ny, want.nz, want.eor, want.eof);
               $display("%0t:                 actual   x=%0d y=%0d z=%0d eor=%0b eof=%0b",
                        $time, got.nx, got.ny, got.nz, got.eor, got.eof);
               error_count++;
            end
         end
      end
   end

   // hard stop on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      req.valid         <= 1'b0;
      req.height_sample <= 16'd0;
      csr.valid         <= 1'b0;
      csr.index         <= REG_SRC_WIDTH;
      csr.data          <= 16'd0;
      left_height = 16'd0;
      col_pos     = 0;
      row_pos     = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_width();
      test_random_frames();
      drain();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
